FILE: hdl/rsd_pkg.sv
// ----------------------------------------------------------------------------
// rsd_pkg
// Shared types and constants of the ray slot dispatcher.
// ----------------------------------------------------------------------------
package rsd_pkg;

    localparam int DEF_SLOTS        = 32;
    localparam int DEF_RING_DEPTH   = 64;
    localparam int DEF_IMAGE_WIDTH  = 640;
    localparam int DEF_IMAGE_HEIGHT = 480;

    localparam int CLUSTER_W = 16;
    localparam int LOCAL_W   = 16;
    localparam int X_W       = 10;
    localparam int Y_W       = 9;
    localparam int PAYLOAD_W = 64;
    localparam int SLOT_W    = 5;
    localparam int SOURCE_W  = 2;
    localparam int BACKLOG_W = 6;
    localparam int DROPS_W   = 6;
    localparam int CMD_W     = 2;
    localparam int COLS_W    = 10;
    localparam int IDLE_W    = 16;
    localparam int FRAME_W   = 32;

    localparam int ENTRY_W = CLUSTER_W + LOCAL_W + X_W + Y_W + PAYLOAD_W;
    localparam int S_DATA_W = ((ENTRY_W + 7) / 8) * 8;
    localparam int M_BODY_W = SLOT_W + ENTRY_W + BACKLOG_W + DROPS_W;
    localparam int M_DATA_W = ((M_BODY_W + 7) / 8) * 8;
    localparam int M_USER_W = SOURCE_W + 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [COLS_W-1:0] COLS_RESET = COLS_W'(2);
    localparam logic [IDLE_W-1:0] IDLE_RESET = IDLE_W'(200);

    typedef enum logic [CMD_W-1:0] {
        CMD_BEGIN = 2'd0,
        CMD_SPILL = 2'd1,
        CMD_END   = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [SOURCE_W-1:0] {
        SRC_RING  = 2'd0,
        SRC_SPILL = 2'd1,
        SRC_GEN   = 2'd2
    } t_source;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLUSTER = 3'd0,
        CFG_LOCAL   = 3'd1,
        CFG_COLUMNS = 3'd2,
        CFG_IDLE    = 3'd3,
        CFG_PAYLOAD = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SPILL,
        S_DRAIN_RD,
        S_DRAIN_OUT,
        S_END,
        S_SWEEP_DIV,
        S_SWEEP_SET,
        S_PHASE_DIV,
        S_PHASE_CHK,
        S_GEN_MUL,
        S_GEN_SET,
        S_GEN,
        S_MARK
    } t_state;

endpackage

FILE: hdl/rsd_ram.sv
// ----------------------------------------------------------------------------
// rsd_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/ray_slot_dispatcher_with_backlog.sv
// ----------------------------------------------------------------------------
// ray_slot_dispatcher_with_backlog
// Fills per-frame output slots from a backlog ring, spill rays and a
// column-sweep ray generator.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tuser = command (begin frame, spill ray, end frame),
//   tdata = the spill ray. Master stream: one request per emitted ray or
//   frame marker, tlast on the final request of each input request.
//   Configuration: write i_cfg_data to register i_cfg_index while idle.
// Sequencing:
//   Spill: a request when sent to a slot, none when queued or dropped.
//   Begin frame: drains ring rays into free slots (registered RAM read).
//   End frame: two passes of the shared restoring divider (sweep length,
//   then frame phase), setup, then one generated ray per cycle, held
//   while the output stalls and slots are free, then the frame marker.
//   One request in flight: the slave side is ready only in the idle state.
// Reset clears ring pointers, frame counters and camera and payload regs,
// presets columns and idle; ring contents are undefined until written.
// Receiver stall: the output register holds its request and the sequencer
// waits; nothing is lost.
// ----------------------------------------------------------------------------
module ray_slot_dispatcher_with_backlog
    import rsd_pkg::*;
#(
    parameter int SLOTS        = DEF_SLOTS,
    parameter int RING_DEPTH   = DEF_RING_DEPTH,
    parameter int IMAGE_WIDTH  = DEF_IMAGE_WIDTH,
    parameter int IMAGE_HEIGHT = DEF_IMAGE_HEIGHT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // cluster[15:0] local[31:16] x[41:32] y[50:42] payload[114:51] pad
    input  logic [S_DATA_W-1:0]   i_s_axis_tdata,
    // command[1:0]
    input  logic [CMD_W-1:0]      i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // slot[4:0] cluster[20:5] local[36:21] x[46:37] y[55:47]
    // payload[119:56] backlog[125:120] frame_drops[131:126] pad
    output logic [M_DATA_W-1:0]   o_m_axis_tdata,
    // source[1:0] frame_marker[2]
    output logic [M_USER_W-1:0]   o_m_axis_tuser,
    output logic                  o_m_axis_tlast,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW     = $clog2(RING_DEPTH);
    localparam int SW     = $clog2(SLOTS + 1);
    localparam int BW     = $clog2(SLOTS + RING_DEPTH + 1);
    localparam int XW     = $clog2(IMAGE_WIDTH + 1);
    localparam int YW     = $clog2(IMAGE_HEIGHT + 1);
    localparam int HW     = $clog2(IMAGE_HEIGHT + 1);
    localparam int SWP_W  = $clog2(IMAGE_WIDTH + 1024);
    localparam int DEN_W  = ((SWP_W > IDLE_W) ? SWP_W : IDLE_W) + 1;
    localparam int CH_W   = COLS_W + HW;
    localparam int CNT_W  = $clog2(FRAME_W);

    localparam logic [SW-1:0]     SLOTS_V  = SW'(SLOTS);
    localparam logic [AW:0]       DEPTH_V  = (AW+1)'(RING_DEPTH);
    localparam logic [AW-1:0]     LAST_IDX = AW'(RING_DEPTH - 1);
    localparam logic [XW-1:0]     X_LAST   = XW'(IMAGE_WIDTH - 1);
    localparam logic [YW-1:0]     Y_LAST   = YW'(IMAGE_HEIGHT - 1);
    localparam logic [HW-1:0]     HEIGHT_V = HW'(IMAGE_HEIGHT);
    localparam logic [CNT_W-1:0]  DIV_LAST = CNT_W'(FRAME_W - 1);

    t_state r_state, n_state;

    logic [CLUSTER_W-1:0]  r_cam_cluster;
    logic [LOCAL_W-1:0]    r_cam_local;
    logic [COLS_W-1:0]     r_cols;
    logic [IDLE_W-1:0]     r_idle;
    logic [PAYLOAD_W-1:0]  r_fresh;

    logic [AW-1:0]      r_head, r_tail;
    logic [SW-1:0]      r_slots, r_spills, r_drops;
    logic [FRAME_W-1:0] r_frame_count;
    logic [AW-1:0]      r_fin;

    logic [FRAME_W-1:0] r_div_num;
    logic [DEN_W-1:0]   r_div_den;
    logic [DEN_W-1:0]   r_div_rem;
    logic [CNT_W-1:0]   r_div_cnt;
    logic [SWP_W-1:0]   r_sweep;
    logic [XW-1:0]      r_base;
    logic [CH_W-1:0]    r_cols_h;
    logic [BW-1:0]      r_budget;
    logic [BW-1:0]      r_free_slots;
    logic [BW-1:0]      r_gen_left;
    logic [XW-1:0]      r_gx;
    logic [YW-1:0]      r_gy;

    logic [ENTRY_W-1:0] r_spill_entry;

    logic                 r_ovalid;
    logic [SW-1:0]        r_o_slot;
    logic [SOURCE_W-1:0]  r_o_source;
    logic [ENTRY_W-1:0]   r_o_entry;
    logic                 r_o_marker;
    logic [AW-1:0]        r_o_backlog;
    logic [SW-1:0]        r_o_drops;
    logic                 r_o_last;

    logic               in_acc, out_free;
    logic [AW-1:0]      head_inc, tail_inc, count;
    logic [AW:0]        count_wide;
    logic               ring_empty, ring_full, slots_free;
    logic               ram_we;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata, gen_entry, in_entry;
    logic [DEN_W:0]     div_sh;
    logic               div_ge;
    logic [DEN_W-1:0]   div_rem_nx;
    logic [BW-1:0]      gen_total;
    logic [CMD_W-1:0]   cmd;

    logic [SW+SLOT_W-1:0]    slot_ext;
    logic [AW+BACKLOG_W-1:0] backlog_ext;
    logic [SW+DROPS_W-1:0]   drops_ext;
    logic [XW+X_W-1:0]       gx_ext;
    logic [YW+Y_W-1:0]       gy_ext;

    assign cmd      = i_s_axis_tuser;
    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_ovalid || i_m_axis_tready;

    assign head_inc   = (r_head == LAST_IDX) ? '0 : r_head + AW'(1);
    assign tail_inc   = (r_tail == LAST_IDX) ? '0 : r_tail + AW'(1);
    assign count_wide = (r_tail >= r_head) ? {1'b0, r_tail} - {1'b0, r_head}
                                           : {1'b0, r_tail} + DEPTH_V - {1'b0, r_head};
    assign count      = count_wide[AW-1:0];
    assign ring_empty = (r_head == r_tail);
    assign ring_full  = (tail_inc == r_head);
    assign slots_free = (r_slots < SLOTS_V);

    assign in_entry = i_s_axis_tdata[ENTRY_W-1:0];
    assign gx_ext   = {{X_W{1'b0}}, r_gx};
    assign gy_ext   = {{Y_W{1'b0}}, r_gy};
    assign gen_entry = {r_fresh, gy_ext[Y_W-1:0], gx_ext[X_W-1:0], r_cam_local,
                        r_cam_cluster};

    assign div_sh     = {r_div_rem, r_div_num[FRAME_W-1]};
    assign div_ge     = (div_sh >= {1'b0, r_div_den});
    assign div_rem_nx = div_ge ? DEN_W'(div_sh - {1'b0, r_div_den}) : div_sh[DEN_W-1:0];

    assign gen_total = ({{BW{1'b0}}, r_cols_h} < {{CH_W{1'b0}}, r_budget})
                       ? BW'(r_cols_h) : r_budget;

    rsd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tail),
        .i_wdata (ram_wdata),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (cmd)
                        CMD_BEGIN: n_state = S_DRAIN_RD;
                        CMD_SPILL: begin
                            if (r_spills < SLOTS_V && slots_free) begin
                                n_state = S_SPILL;
                            end
                        end
                        CMD_END:   n_state = S_END;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_SPILL:     if (out_free) n_state = S_IDLE;
            S_DRAIN_RD:  n_state = (slots_free && !ring_empty) ? S_DRAIN_OUT : S_IDLE;
            S_DRAIN_OUT: if (out_free) n_state = S_DRAIN_RD;
            S_END:       n_state = (r_cols == '0) ? S_MARK : S_SWEEP_DIV;
            S_SWEEP_DIV: if (r_div_cnt == DIV_LAST) n_state = S_SWEEP_SET;
            S_SWEEP_SET: n_state = S_PHASE_DIV;
            S_PHASE_DIV: if (r_div_cnt == DIV_LAST) n_state = S_PHASE_CHK;
            S_PHASE_CHK: begin
                n_state = ({{SWP_W{1'b0}}, r_div_rem} >= {{DEN_W{1'b0}}, r_sweep})
                          ? S_MARK : S_GEN_MUL;
            end
            S_GEN_MUL:   n_state = S_GEN_SET;
            S_GEN_SET:   n_state = S_GEN;
            S_GEN:       if (r_gen_left == '0) n_state = S_MARK;
            S_MARK:      if (out_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_s_axis_tready = (r_state == S_IDLE);
        ram_we          = 1'b0;
        ram_wdata       = in_entry;
        case (r_state)
            S_IDLE: begin
                ram_we = in_acc && (cmd == CMD_SPILL) && (r_spills < SLOTS_V)
                         && !slots_free && !ring_full;
            end
            S_GEN: begin
                ram_we    = (r_gen_left != '0) && !slots_free;
                ram_wdata = gen_entry;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cam_cluster <= '0;
            r_cam_local   <= '0;
            r_cols        <= COLS_RESET;
            r_idle        <= IDLE_RESET;
            r_fresh       <= '0;
            r_head        <= '0;
            r_tail        <= '0;
            r_slots       <= '0;
            r_spills      <= '0;
            r_drops       <= '0;
            r_frame_count <= '0;
            r_ovalid      <= 1'b0;
            r_div_cnt     <= '0;
        end else begin
            r_state <= n_state;
            if (r_ovalid && i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (ram_we) begin
                r_tail <= tail_inc;
            end

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CLUSTER: r_cam_cluster <= i_cfg_data[CLUSTER_W-1:0];
                    CFG_LOCAL:   r_cam_local   <= i_cfg_data[LOCAL_W-1:0];
                    CFG_COLUMNS: r_cols        <= i_cfg_data[COLS_W-1:0];
                    CFG_IDLE:    r_idle        <= i_cfg_data[IDLE_W-1:0];
                    CFG_PAYLOAD: r_fresh       <= i_cfg_data;
                    default:     r_fresh       <= r_fresh;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (cmd)
                            CMD_BEGIN: begin
                                r_slots  <= '0;
                                r_spills <= '0;
                                r_drops  <= '0;
                                r_fin    <= ({{(BW-AW){1'b0}}, count} > BW'(SLOTS))
                                            ? AW'({{(BW-AW){1'b0}}, count} - BW'(SLOTS))
                                            : '0;
                            end
                            CMD_SPILL: begin
                                if (r_spills < SLOTS_V) begin
                                    r_spills      <= r_spills + SW'(1);
                                    r_spill_entry <= in_entry;
                                    if (!slots_free && ring_full) begin
                                        r_drops <= r_drops + SW'(1);
                                    end
                                end
                            end
                            default: begin
                                r_fin <= r_fin;
                            end
                        endcase
                    end
                end
                S_SPILL: begin
                    if (out_free) begin
                        r_ovalid    <= 1'b1;
                        r_o_slot    <= r_slots;
                        r_o_source  <= SRC_SPILL;
                        r_o_entry   <= r_spill_entry;
                        r_o_marker  <= 1'b0;
                        r_o_backlog <= count;
                        r_o_drops   <= r_drops;
                        r_o_last    <= 1'b1;
                        r_slots     <= r_slots + SW'(1);
                    end
                end
                S_DRAIN_OUT: begin
                    if (out_free) begin
                        r_ovalid    <= 1'b1;
                        r_o_slot    <= r_slots;
                        r_o_source  <= SRC_RING;
                        r_o_entry   <= ram_rdata;
                        r_o_marker  <= 1'b0;
                        r_o_backlog <= r_fin;
                        r_o_drops   <= r_drops;
                        r_o_last    <= (r_slots + SW'(1) == SLOTS_V) || (head_inc == r_tail);
                        r_slots     <= r_slots + SW'(1);
                        r_head      <= head_inc;
                    end
                end
                S_END: begin
                    r_div_num <= FRAME_W'(IMAGE_WIDTH) + FRAME_W'(r_cols) - FRAME_W'(1);
                    r_div_den <= DEN_W'(r_cols);
                    r_div_rem <= '0;
                    r_div_cnt <= '0;
                end
                S_SWEEP_DIV, S_PHASE_DIV: begin
                    r_div_rem <= div_rem_nx;
                    r_div_num <= {r_div_num[FRAME_W-2:0], div_ge};
                    r_div_cnt <= r_div_cnt + CNT_W'(1);
                end
                S_SWEEP_SET: begin
                    r_sweep   <= r_div_num[SWP_W-1:0];
                    r_div_num <= r_frame_count;
                    r_div_den <= DEN_W'(r_div_num[SWP_W-1:0]) + DEN_W'(r_idle);
                    r_div_rem <= '0;
                    r_div_cnt <= '0;
                end
                S_GEN_MUL: begin
                    r_base       <= XW'(r_div_rem[SWP_W-1:0] * r_cols);
                    r_cols_h     <= r_cols * HEIGHT_V;
                    r_free_slots <= BW'(SLOTS_V - r_slots);
                    r_budget     <= BW'(SLOTS_V - r_slots) + BW'(LAST_IDX - count);
                end
                S_GEN_SET: begin
                    r_gen_left <= gen_total;
                    r_gx       <= r_base;
                    r_gy       <= '0;
                    r_fin      <= (gen_total > r_free_slots)
                                  ? count + AW'(gen_total - r_free_slots) : count;
                end
                S_GEN: begin
                    if (r_gen_left != '0 && (!slots_free || out_free)) begin
                        if (slots_free) begin
                            r_ovalid    <= 1'b1;
                            r_o_slot    <= r_slots;
                            r_o_source  <= SRC_GEN;
                            r_o_entry   <= gen_entry;
                            r_o_marker  <= 1'b0;
                            r_o_backlog <= r_fin;
                            r_o_drops   <= r_drops;
                            r_o_last    <= 1'b0;
                            r_slots     <= r_slots + SW'(1);
                        end
                        r_gen_left <= r_gen_left - BW'(1);
                        if (r_gy == Y_LAST) begin
                            r_gy <= '0;
                            r_gx <= (r_gx == X_LAST) ? '0 : r_gx + XW'(1);
                        end else begin
                            r_gy <= r_gy + YW'(1);
                        end
                    end
                end
                S_MARK: begin
                    if (out_free) begin
                        r_ovalid      <= 1'b1;
                        r_o_slot      <= r_slots;
                        r_o_source    <= SRC_RING;
                        r_o_entry     <= '0;
                        r_o_marker    <= 1'b1;
                        r_o_backlog   <= count;
                        r_o_drops     <= r_drops;
                        r_o_last      <= 1'b1;
                        r_frame_count <= r_frame_count + FRAME_W'(1);
                    end
                end
                default: begin
                    r_div_cnt <= r_div_cnt;
                end
            endcase
        end
    end

    assign slot_ext    = {{SLOT_W{1'b0}}, r_o_slot};
    assign backlog_ext = {{BACKLOG_W{1'b0}}, r_o_backlog};
    assign drops_ext   = {{DROPS_W{1'b0}}, r_o_drops};

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tlast  = r_o_last;
    assign o_m_axis_tuser  = {r_o_marker, r_o_source};
    assign o_m_axis_tdata  = {{(M_DATA_W-M_BODY_W){1'b0}}, drops_ext[DROPS_W-1:0],
                              backlog_ext[BACKLOG_W-1:0], r_o_entry,
                              slot_ext[SLOT_W-1:0]};

endmodule

FILE: tb/sv/tb_ray_slot_dispatcher_with_backlog.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ray_slot_dispatcher_with_backlog
// Self-checking bench for the ray slot dispatcher. A queue of frame
// commands feeds a clocked driver. A scoreboard model of slots, backlog ring
// and sweep generator predicts every output request. A clocked monitor
// compares each request field by field, under random stalls on both sides
// and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_ray_slot_dispatcher_with_backlog;
    import rsd_pkg::*;

    localparam int NSLOT = DEF_SLOTS;
    localparam int DEPTH = DEF_RING_DEPTH;
    localparam int IMG_W = DEF_IMAGE_WIDTH;
    localparam int IMG_H = DEF_IMAGE_HEIGHT;

    typedef struct {
        t_cmd                 cmd;
        logic [CLUSTER_W-1:0] cluster;
        logic [LOCAL_W-1:0]   lcl;
        logic [X_W-1:0]       x;
        logic [Y_W-1:0]       y;
        logic [PAYLOAD_W-1:0] payload;
    } t_ray_cmd;

    typedef struct {
        logic [SLOT_W-1:0]    slot;
        logic [SOURCE_W-1:0]  source;
        logic [CLUSTER_W-1:0] cluster;
        logic [LOCAL_W-1:0]   lcl;
        logic [X_W-1:0]       x;
        logic [Y_W-1:0]       y;
        logic [PAYLOAD_W-1:0] payload;
        logic                 marker;
        logic [BACKLOG_W-1:0] backlog;
        logic [DROPS_W-1:0]   drops;
        logic                 last;
    } t_ray_out;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  o_s_axis_tready;
    logic [S_DATA_W-1:0]   s_data = '0;
    logic [CMD_W-1:0]      s_user = '0;
    logic                  o_m_axis_tvalid;
    logic                  m_ready = 1'b0;
    logic [M_DATA_W-1:0]   o_m_axis_tdata;
    logic [M_USER_W-1:0]   o_m_axis_tuser;
    logic                  o_m_axis_tlast;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    ray_slot_dispatcher_with_backlog uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // dispatcher model state
    logic [CLUSTER_W-1:0] ring_cl [DEPTH];
    logic [LOCAL_W-1:0]   ring_lo [DEPTH];
    logic [X_W-1:0]       ring_x  [DEPTH];
    logic [Y_W-1:0]       ring_y  [DEPTH];
    logic [PAYLOAD_W-1:0] ring_pl [DEPTH];
    int unsigned          ring_head = 0, ring_tail = 0;
    int unsigned          slots_used = 0, spills_seen = 0, drops = 0;
    int unsigned          frame_cnt = 0;
    logic [CLUSTER_W-1:0] cam_cluster = '0;
    logic [LOCAL_W-1:0]   cam_local = '0;
    logic [COLS_W-1:0]    sweep_cols = COLS_RESET;
    logic [IDLE_W-1:0]    idle_cnt = IDLE_RESET;
    logic [PAYLOAD_W-1:0] fresh_pl = '0;

    t_ray_cmd    pending_cmds[$];
    t_ray_out    expected_rays[$];
    t_ray_cmd    cur_cmd;
    int          src_gap = 0;
    int          sink_wait = 0;
    logic        no_idle = 1'b0;
    int          errors = 0;
    logic        hold_start = 1'b0;
    logic        hold_done = 1'b0;
    int          hold_cnt = 0;
    wire         hold_off = (hold_cnt != 0);

    function automatic int unsigned ring_level();
        return (ring_tail + DEPTH - ring_head) % DEPTH;
    endfunction

    function automatic t_ray_out make_ray(int unsigned slot, logic [1:0] src,
            logic [15:0] cl, logic [15:0] lo, logic [9:0] x, logic [8:0] y,
            logic [63:0] pl, logic mk);
        t_ray_out r;
        r.slot = slot[SLOT_W-1:0];
        r.source = src;
        r.cluster = cl;
        r.lcl = lo;
        r.x = x;
        r.y = y;
        r.payload = pl;
        r.marker = mk;
        r.backlog = '0;
        r.drops = '0;
        r.last = 1'b0;
        return r;
    endfunction

    function automatic bit ring_push(logic [15:0] cl, logic [15:0] lo, logic [9:0] x,
            logic [8:0] y, logic [63:0] pl);
        int unsigned nt;
        nt = (ring_tail + 1) % DEPTH;
        if (nt == ring_head) return 1'b0;
        ring_cl[ring_tail] = cl;
        ring_lo[ring_tail] = lo;
        ring_x[ring_tail] = x;
        ring_y[ring_tail] = y;
        ring_pl[ring_tail] = pl;
        ring_tail = nt;
        return 1'b1;
    endfunction

    task automatic dispatch_rays(input t_ray_cmd c);
        t_ray_out    rays[$];
        int unsigned sweep, phase, budget, xc, col, row;
        bit          ok;
        case (c.cmd)
            CMD_BEGIN: begin
                slots_used = 0;
                spills_seen = 0;
                drops = 0;
                while (slots_used < NSLOT && ring_head != ring_tail) begin
                    rays.push_back(make_ray(slots_used, SRC_RING, ring_cl[ring_head],
                        ring_lo[ring_head], ring_x[ring_head], ring_y[ring_head],
                        ring_pl[ring_head], 1'b0));
                    slots_used++;
                    ring_head = (ring_head + 1) % DEPTH;
                end
            end
            CMD_SPILL: begin
                if (spills_seen < NSLOT) begin
                    spills_seen++;
                    if (slots_used < NSLOT) begin
                        rays.push_back(make_ray(slots_used, SRC_SPILL, c.cluster, c.lcl,
                            c.x, c.y, c.payload, 1'b0));
                        slots_used++;
                    end else begin
                        ok = ring_push(c.cluster, c.lcl, c.x, c.y, c.payload);
                        if (!ok) drops++;
                    end
                end
            end
            CMD_END: begin
                if (sweep_cols != 0) begin
                    sweep = (IMG_W + sweep_cols - 1) / sweep_cols;
                    phase = frame_cnt % (sweep + idle_cnt);
                    if (phase < sweep) begin
                        budget = (NSLOT - slots_used) + (DEPTH - 1 - ring_level());
                        for (col = 0; col < sweep_cols && budget != 0; col++) begin
                            xc = (phase * sweep_cols + col) % IMG_W;
                            for (row = 0; row < IMG_H && budget != 0; row++) begin
                                if (slots_used < NSLOT) begin
                                    rays.push_back(make_ray(slots_used, SRC_GEN, cam_cluster,
                                        cam_local, xc[9:0], row[8:0], fresh_pl, 1'b0));
                                    slots_used++;
                                end else begin
                                    ok = ring_push(cam_cluster, cam_local, xc[9:0],
                                        row[8:0], fresh_pl);
                                end
                                budget--;
                            end
                        end
                    end
                end
                rays.push_back(make_ray(slots_used, SRC_RING, '0, '0, '0, '0, '0, 1'b1));
                frame_cnt++;
            end
            default: ;
        endcase
        foreach (rays[k]) begin
            rays[k].backlog = BACKLOG_W'(ring_level());
            rays[k].drops = DROPS_W'(drops);
            rays[k].last = (k == rays.size() - 1);
            expected_rays.push_back(rays[k]);
        end
    endtask

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        if (errors < 40)
            $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // source side
    always @(posedge i_clk) begin
        logic fire;
        t_ray_cmd c;
        fire = s_valid && o_s_axis_tready;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (fire) dispatch_rays(cur_cmd);
            if (!s_valid || fire) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    s_valid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    c = pending_cmds.pop_front();
                    cur_cmd <= c;
                    s_user <= c.cmd;
                    s_data <= {5'd0, c.payload, c.y, c.x, c.lcl, c.cluster};
                    s_valid <= 1'b1;
                    src_gap <= no_idle ? 0 : $urandom_range(0, 19);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_start && !hold_done) begin
            hold_cnt <= 3000;
            hold_done <= 1'b1;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // sink side
    always @(posedge i_clk) begin
        logic fire;
        int nw;
        t_ray_out w;
        fire = o_m_axis_tvalid && m_ready;
        if (fire) begin
            if (expected_rays.size() == 0) begin
                report("unexpected request", o_m_axis_tdata[63:0], 64'd0);
            end else begin
                w = expected_rays.pop_front();
                if (o_m_axis_tdata[4:0] !== w.slot) report("slot", o_m_axis_tdata[4:0], w.slot);
                if (o_m_axis_tuser[1:0] !== w.source)
                    report("source", o_m_axis_tuser[1:0], w.source);
                if (o_m_axis_tuser[2] !== w.marker)
                    report("frame_marker", o_m_axis_tuser[2], w.marker);
                if (o_m_axis_tdata[20:5] !== w.cluster)
                    report("cluster", o_m_axis_tdata[20:5], w.cluster);
                if (o_m_axis_tdata[36:21] !== w.lcl)
                    report("local", o_m_axis_tdata[36:21], w.lcl);
                if (o_m_axis_tdata[46:37] !== w.x) report("x", o_m_axis_tdata[46:37], w.x);
                if (o_m_axis_tdata[55:47] !== w.y) report("y", o_m_axis_tdata[55:47], w.y);
                if (o_m_axis_tdata[119:56] !== w.payload)
                    report("payload", o_m_axis_tdata[119:56], w.payload);
                if (o_m_axis_tdata[125:120] !== w.backlog)
                    report("backlog", o_m_axis_tdata[125:120], w.backlog);
                if (o_m_axis_tdata[131:126] !== w.drops)
                    report("frame_drops", o_m_axis_tdata[131:126], w.drops);
                if (o_m_axis_tlast !== w.last) report("tlast", o_m_axis_tlast, w.last);
            end
        end
        if (fire) nw = no_idle ? 0 : $urandom_range(0, 19);
        else nw = (sink_wait > 0) ? sink_wait - 1 : 0;
        sink_wait <= nw;
        m_ready <= i_rst_n && !hold_off && (nw == 0);
    end

    function automatic t_ray_cmd rand_ray(t_cmd cmd);
        t_ray_cmd c;
        c.cmd = cmd;
        c.cluster = CLUSTER_W'($urandom);
        c.lcl = LOCAL_W'($urandom);
        c.x = ($urandom_range(0, 7) == 0) ? X_W'($urandom_range(0, 1023))
                                          : X_W'($urandom_range(0, 639));
        c.y = ($urandom_range(0, 7) == 0) ? Y_W'($urandom_range(0, 511))
                                          : Y_W'($urandom_range(0, 479));
        c.payload = {$urandom, $urandom};
        return c;
    endfunction

    task automatic queue_frame();
        int n;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(28, 70) : $urandom_range(0, 12);
        if ($urandom_range(0, 5) != 0) pending_cmds.push_back(rand_ray(CMD_BEGIN));
        repeat (n) pending_cmds.push_back(rand_ray(CMD_SPILL));
        if ($urandom_range(0, 7) == 0) pending_cmds.push_back(rand_ray(CMD_NONE));
        pending_cmds.push_back(rand_ray(CMD_END));
    endtask

    task automatic queue_random(int items);
        int start;
        t_cmd any;
        start = pending_cmds.size();
        while (pending_cmds.size() - start < items) begin
            if ($urandom_range(0, 9) == 0) begin
                any = t_cmd'($urandom_range(0, 3));
                pending_cmds.push_back(rand_ray(any));
            end else begin
                queue_frame();
            end
        end
    endtask

    task automatic drain_all();
        while (pending_cmds.size() > 0 || s_valid || expected_rays.size() > 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [63:0] value);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_CLUSTER: cam_cluster = value[15:0];
            CFG_LOCAL:   cam_local = value[15:0];
            CFG_COLUMNS: sweep_cols = value[9:0];
            CFG_IDLE:    idle_cnt = value[15:0];
            CFG_PAYLOAD: fresh_pl = value;
            default: ;
        endcase
    endtask

    task automatic write_all(logic [15:0] cl, logic [15:0] lo, logic [9:0] cols,
            logic [15:0] idle, logic [63:0] pl);
        write_reg(CFG_CLUSTER, 64'(cl));
        write_reg(CFG_LOCAL, 64'(lo));
        write_reg(CFG_COLUMNS, 64'(cols));
        write_reg(CFG_IDLE, 64'(idle));
        write_reg(CFG_PAYLOAD, pl);
    endtask

    initial begin
        t_ray_cmd c;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (3) @(posedge i_clk);

        // directed: extremes, every command, full frame, overflow and drops
        pending_cmds.push_back(rand_ray(CMD_BEGIN));
        c = rand_ray(CMD_SPILL);
        c.cluster = '1; c.lcl = '1; c.x = '1; c.y = '1; c.payload = '1;
        pending_cmds.push_back(c);
        c.cluster = '0; c.lcl = '0; c.x = '0; c.y = '0; c.payload = '0;
        pending_cmds.push_back(c);
        pending_cmds.push_back(rand_ray(CMD_NONE));
        pending_cmds.push_back(rand_ray(CMD_END));
        pending_cmds.push_back(rand_ray(CMD_BEGIN));
        pending_cmds.push_back(rand_ray(CMD_END));
        drain_all();
        write_all(16'hFFFF, 16'hFFFF, 10'd640, 16'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        pending_cmds.push_back(rand_ray(CMD_END));
        repeat (8) pending_cmds.push_back(rand_ray(CMD_SPILL));
        pending_cmds.push_back(rand_ray(CMD_BEGIN));
        repeat (4) pending_cmds.push_back(rand_ray(CMD_SPILL));
        pending_cmds.push_back(rand_ray(CMD_END));
        drain_all();

        queue_random(30);
        drain_all();
        write_all(16'h0000, 16'($urandom), 10'd1, 16'hFFFF, {$urandom, $urandom});
        no_idle <= 1'b1;
        queue_random(20);
        drain_all();
        write_all(16'($urandom), 16'($urandom), 10'd0, 16'($urandom), {$urandom, $urandom});
        no_idle <= 1'b0;
        queue_random(10);
        drain_all();
        write_all(16'($urandom), 16'($urandom), 10'($urandom_range(1, 640)),
            16'($urandom_range(0, 3)), {$urandom, $urandom});
        hold_start <= 1'b1;
        queue_random(40);
        drain_all();

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
